/* rtl/spmv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_pkg
// shared types, widths and codes for the sparse matrix-vector engine
// ----------------------------------------------------------------------------
package spmv_pkg;

    localparam int VEC_LEN    = 1024;
    localparam int ADDR_W     = $clog2(VEC_LEN);
    localparam int X_W        = 32;
    localparam int Y_W        = 48;
    localparam int PROD_W     = 2 * X_W;
    localparam int FRAC_W     = 16;
    localparam int REQ_W      = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD_X = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_Y = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ENTRY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_Y = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_MODE  = 4'd1;

    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 2'd0;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [ADDR_W-1:0]     row_index;
        logic [ADDR_W-1:0]     col_index;
        logic signed [X_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic signed [Y_W-1:0] y_value;
        logic                  overflow_seen;
    } result_t;

endpackage

/* rtl/spmv_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sparse_matrix_vector_multiply_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_core
// y = A*x, y += A*x or y -= A*x over nonzero words with explicit row and
// column, x and y held in two synchronous rams
//
//   channel  direction  word       handshake
//   s_       in         req_t      s_valid / s_ready
//   m_       out        result_t   m_valid / m_ready
//   cfg_     in         index+data cfg_valid / cfg_ready (always ready)
//
// load x, load y, begin without clear and unknown words: done in idle
// read y: read state, held while the output register is still occupied
// matrix entry: mul, acc1, plus acc2 when mirrored (two y ram port passes)
// begin in overwrite mode: a clearing pass over the y ram
// reset is synchronous and active low; the rams hold no reset state
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_core
    import spmv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC1 = 3'd3;
    localparam logic [2:0] ST_ACC2 = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [MODE_W-1:0]       sign_mode_reg;
    logic                    sym_mode_reg;
    logic                    ovf_reg, ovf_next;
    logic [ADDR_W-1:0]       row_reg, row_next;
    logic [ADDR_W-1:0]       col_reg, col_next;
    logic signed [X_W-1:0]   val_reg, val_next;
    logic                    mirror_reg, mirror_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    m_valid_reg, m_valid_next;
    result_t                 m_data_reg, m_data_next;

    logic                    x_wr_en, x_rd_en;
    logic [ADDR_W-1:0]       x_wr_addr, x_rd_addr;
    logic [X_W-1:0]          x_wr_data, x_rd_data;
    logic                    y_wr_en, y_rd_en;
    logic [ADDR_W-1:0]       y_wr_addr, y_rd_addr;
    logic [Y_W-1:0]          y_wr_data, y_rd_data;

    logic                    accept;
    logic signed [X_W-1:0]   x_rd_s;
    logic [Y_W-1:0]          term;
    logic [Y_W:0]            sum;
    logic [Y_W-1:0]          acc_value;
    logic                    acc_sat;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign x_rd_s    = x_rd_data;

    spmv_ram #(.WIDTH(X_W), .DEPTH(VEC_LEN)) u_x_ram (
        .aclk    (aclk),
        .wr_en   (x_wr_en),
        .wr_addr (x_wr_addr),
        .wr_data (x_wr_data),
        .rd_en   (x_rd_en),
        .rd_addr (x_rd_addr),
        .rd_data (x_rd_data)
    );

    spmv_ram #(.WIDTH(Y_W), .DEPTH(VEC_LEN)) u_y_ram (
        .aclk    (aclk),
        .wr_en   (y_wr_en),
        .wr_addr (y_wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (y_rd_en),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

    // floor of the q32.32 product, then saturating add or subtract
    always_comb begin
        term = prod_reg[PROD_W-1:FRAC_W];
        if (sign_mode_reg[1]) begin
            sum = {y_rd_data[Y_W-1], y_rd_data} - {term[Y_W-1], term};
        end else begin
            sum = {y_rd_data[Y_W-1], y_rd_data} + {term[Y_W-1], term};
        end
        acc_sat = (sum[Y_W] != sum[Y_W-1]);
        if (!acc_sat) begin
            acc_value = sum[Y_W-1:0];
        end else if (sum[Y_W]) begin
            acc_value = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            acc_value = {1'b0, {(Y_W-1){1'b1}}};
        end
    end

    always_comb begin
        state_next   = state_reg;
        ovf_next     = ovf_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        val_next     = val_reg;
        mirror_next  = mirror_reg;
        prod_next    = prod_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        x_wr_en   = 1'b0;
        x_wr_addr = s_data.row_index;
        x_wr_data = s_data.data_value;
        x_rd_en   = 1'b0;
        x_rd_addr = s_data.col_index;
        y_wr_en   = 1'b0;
        y_wr_addr = s_data.row_index;
        y_wr_data = {{(Y_W-X_W){s_data.data_value[X_W-1]}}, s_data.data_value};
        y_rd_en   = 1'b0;
        y_rd_addr = s_data.row_index;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    row_next = s_data.row_index;
                    col_next = s_data.col_index;
                    val_next = s_data.data_value;
                    case (s_data.req_type)
                        REQ_LOAD_X: begin
                            x_wr_en = 1'b1;
                        end
                        REQ_LOAD_Y: begin
                            y_wr_en = 1'b1;
                        end
                        REQ_ENTRY: begin
                            x_rd_en     = 1'b1;
                            mirror_next = sym_mode_reg &&
                                          (s_data.row_index != s_data.col_index);
                            state_next  = ST_MUL;
                        end
                        REQ_READ_Y: begin
                            y_rd_en    = 1'b1;
                            state_next = ST_READ;
                        end
                        REQ_BEGIN: begin
                            ovf_next = 1'b0;
                            if (sign_mode_reg == MODE_OVERWRITE) begin
                                clr_cnt_next = '0;
                                state_next   = ST_CLR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.y_value       = y_rd_data;
                    m_data_next.overflow_seen = ovf_reg;
                    state_next                = ST_IDLE;
                end
            end
            ST_MUL: begin
                prod_next = val_reg * x_rd_s;
                x_rd_en   = 1'b1;
                x_rd_addr = row_reg;
                y_rd_en   = 1'b1;
                y_rd_addr = row_reg;
                state_next = ST_ACC1;
            end
            ST_ACC1: begin
                y_wr_en   = 1'b1;
                y_wr_addr = row_reg;
                y_wr_data = acc_value;
                ovf_next  = ovf_reg || acc_sat;
                prod_next = val_reg * x_rd_s;
                if (mirror_reg) begin
                    y_rd_en    = 1'b1;
                    y_rd_addr  = col_reg;
                    state_next = ST_ACC2;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC2: begin
                y_wr_en    = 1'b1;
                y_wr_addr  = col_reg;
                y_wr_data  = acc_value;
                ovf_next   = ovf_reg || acc_sat;
                state_next = ST_IDLE;
            end
            ST_CLR: begin
                y_wr_en      = 1'b1;
                y_wr_addr    = clr_cnt_reg;
                y_wr_data    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(VEC_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sign_mode_reg <= '0;
            sym_mode_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SIGN_MODE) begin
                    sign_mode_reg <= cfg_data[MODE_W-1:0];
                end else if (cfg_index == CFG_SYM_MODE) begin
                    sym_mode_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        val_reg    <= val_next;
        mirror_reg <= mirror_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* rtl/spmv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmv_checker
// port-level checks on the sparse matrix-vector engine, bound to the top level
// ----------------------------------------------------------------------------
module spmv_checker
    import spmv_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input req_t                  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input result_t               m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a read keeps the input side closed for the next cycle
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_READ_Y |=> !s_ready)
        else $error("input accepted right after a read");

    // loads leave the input side ready again in the next cycle
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_data.req_type == REQ_LOAD_X || s_data.req_type == REQ_LOAD_Y)
        |=> s_ready)
        else $error("load did not finish in one cycle");

    // a result only appears after a read was taken
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word without a pending read");

endmodule

bind sparse_matrix_vector_multiply_core spmv_checker u_spmv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
